// ===== hdl/lmtf_pkg.sv =====
// ============================================================================
// lmtf_pkg
// Shared types and constants for the lightmap texel finalize block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lmtf_pkg;

    // Default accumulator width of one input channel
    localparam int ACC_BITS_DEF = 16;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Saturation register: 1/256 steps, 256 keeps full color
    localparam int              SAT_W    = 9;
    localparam int              SAT_SH   = 8;
    localparam logic [SAT_W-1:0] SAT_FULL = 9'd256;

    // Output byte and rescale quotient width
    localparam int             PIX_W   = 8;
    localparam int             Q_BITS  = PIX_W;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // ceil(x/3) for x <= 765 as ((x + 2) * 683) >> 11
    localparam int        DIV3_W     = 10;
    localparam int        DIV3_PW    = 20;
    localparam logic [DIV3_W-1:0] DIV3_RECIP = 10'd683;
    localparam logic [DIV3_W-1:0] DIV3_BIAS  = 10'd2;
    localparam int        DIV3_SHIFT = 11;

    // floor(p/255) for p <= 65535 as (p + 1 + (p >> 8)) >> 8
    localparam int DIV255_W = 17;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_LUMA      = 2'd1,
        MODE_FAKE      = 2'd2,
        MODE_INV_ALPHA = 2'd3
    } t_mode;

    typedef enum logic {
        REG_SATURATION = 1'b0,
        REG_MONO_MODE  = 1'b1
    } t_reg_idx;

    // Classification of one texel, carried from front to back
    typedef struct packed {
        t_mode mode;
        logic  scale;   // brightest channel above one byte
    } t_tag;

    localparam int TAG_W  = $bits(t_tag);
    // Side data through the divider: tag, alpha and three channel bytes
    localparam int SIDE_W = TAG_W + 4*PIX_W;

endpackage

`default_nettype wire

// ===== hdl/lmtf_front.sv =====
// ============================================================================
// lmtf_front
// Front pipeline: clamps the channels, finds the brightest one, classifies
// the texel and applies the grey desaturation of normal mode.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lmtf_front #(
    parameter int ACC_BITS = lmtf_pkg::ACC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [ACC_BITS-1:0]    i_red,
    input  wire logic signed [ACC_BITS-1:0]    i_green,
    input  wire logic signed [ACC_BITS-1:0]    i_blue,
    input  wire logic [lmtf_pkg::SAT_W-1:0]    i_saturation,
    input  wire lmtf_pkg::t_mode               i_mode,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [ACC_BITS-2:0]                o_red,
    output logic [ACC_BITS-2:0]                o_green,
    output logic [ACC_BITS-2:0]                o_blue,
    output logic [ACC_BITS-2:0]                o_max,
    output lmtf_pkg::t_tag                     o_tag
);

    localparam int CW = ACC_BITS - 1;           // clamped channel
    localparam int SW = CW + 7;                 // 33r + 34g + 33b
    localparam int RS = SW + 7;                 // reciprocal shift
    localparam int MW = SW + 1;                 // reciprocal width
    localparam int PW = SW + MW;
    localparam int DW = CW + lmtf_pkg::SAT_W;   // desaturation mix
    // ceil(2^RS / 100): exact floor(x/100) for every x below 2^SW
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << RS) / 64'd100) + 64'd1);

    logic w_en;

    // stage 1: clamp
    logic                        r_v1;
    logic [CW-1:0]               r_c1 [3];
    logic [lmtf_pkg::SAT_W-1:0]  r_s1;
    lmtf_pkg::t_mode             r_mode1;
    logic [CW-1:0]               w_clamp [3];
    logic [lmtf_pkg::SAT_W-1:0]  w_sat;

    // stage 2: max and grey sum
    logic                        r_v2;
    logic [CW-1:0]               r_c2 [3];
    logic [CW-1:0]               r_m2;
    logic [SW-1:0]               r_sum2;
    logic [lmtf_pkg::SAT_W-1:0]  r_s2;
    lmtf_pkg::t_tag              r_tag2;
    logic [CW-1:0]               w_max;
    logic [SW-1:0]               w_sum;

    // stage 3: grey level
    logic                        r_v3;
    logic [CW-1:0]               r_c3 [3];
    logic [CW-1:0]               r_m3;
    logic [CW-1:0]               r_grey3;
    logic [lmtf_pkg::SAT_W-1:0]  r_s3;
    lmtf_pkg::t_tag              r_tag3;
    logic [PW-1:0]               w_prod;

    // stage 4: desaturated texel
    logic                        r_v4;
    logic [CW-1:0]               r_c4 [3];
    logic [CW-1:0]               r_m4;
    lmtf_pkg::t_tag              r_tag4;
    logic [DW-1:0]               w_mix [3];

    // whole front moves unless the last stage is stuck on a full queue
    assign w_en    = !r_v4 || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // negative light counts as dark; saturation above full is full
    always_comb begin
        w_clamp[0] = i_red[ACC_BITS-1]   ? '0 : i_red[CW-1:0];
        w_clamp[1] = i_green[ACC_BITS-1] ? '0 : i_green[CW-1:0];
        w_clamp[2] = i_blue[ACC_BITS-1]  ? '0 : i_blue[CW-1:0];
        w_sat      = (i_saturation > lmtf_pkg::SAT_FULL) ? lmtf_pkg::SAT_FULL
                                                          : i_saturation;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1    <= w_clamp;
            r_s1    <= w_sat;
            r_mode1 <= i_mode;
        end
    end

    // brightest channel and weighted sum for the grey level
    always_comb begin
        w_max = (r_c1[0] > r_c1[1]) ? r_c1[0] : r_c1[1];
        if (r_c1[2] > w_max) begin
            w_max = r_c1[2];
        end
        w_sum = SW'(33) * SW'(r_c1[0]) + SW'(34) * SW'(r_c1[1])
              + SW'(33) * SW'(r_c1[2]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c2         <= r_c1;
            r_m2         <= w_max;
            r_sum2       <= w_sum;
            r_s2         <= r_s1;
            r_tag2.mode  <= r_mode1;
            r_tag2.scale <= (w_max > CW'(255));
        end
    end

    // grey = sum / 100 by reciprocal
    assign w_prod = PW'(r_sum2) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c3    <= r_c2;
            r_m3    <= r_m2;
            r_grey3 <= w_prod[RS +: CW];
            r_s3    <= r_s2;
            r_tag3  <= r_tag2;
        end
    end

    // pull each channel toward grey; other modes keep the clamped value
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_mix[l] = DW'(r_c3[l]) * DW'(r_s3)
                     + DW'(r_grey3) * DW'(lmtf_pkg::SAT_FULL - r_s3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_c4[l] <= (r_tag3.mode == lmtf_pkg::MODE_NORMAL)
                         ? w_mix[l][lmtf_pkg::SAT_SH +: CW] : r_c3[l];
            end
            r_m4   <= r_m3;
            r_tag4 <= r_tag3;
        end
    end

    assign o_valid = r_v4;
    assign o_red   = r_c4[0];
    assign o_green = r_c4[1];
    assign o_blue  = r_c4[2];
    assign o_max   = r_m4;
    assign o_tag   = r_tag4;

endmodule

`default_nettype wire

// ===== hdl/lmtf_queue.sv =====
// ============================================================================
// lmtf_queue
// Short first-in first-out queue between the front and the back.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lmtf_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = lmtf_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lmtf_div.sv =====
// ============================================================================
// lmtf_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. The quotient is known to fit in Q_BITS bits.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lmtf_div #(
    parameter int CW     = lmtf_pkg::ACC_BITS_DEF - 1,
    parameter int LANES  = 3,
    parameter int SIDE_W = lmtf_pkg::SIDE_W
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic [CW+lmtf_pkg::Q_BITS-1:0] i_num [LANES],
    input  wire logic [CW-1:0]                  i_den,
    input  wire logic [SIDE_W-1:0]              i_side,
    output logic                                o_valid,
    output logic [lmtf_pkg::Q_BITS-1:0]         o_quot [LANES],
    output logic [SIDE_W-1:0]                   o_side
);

    localparam int QB = lmtf_pkg::Q_BITS;
    localparam int NW = CW + QB;

    logic [QB:0]         r_v;
    logic [NW-1:0]       r_rem  [QB+1][LANES];
    logic [QB-1:0]       r_quot [QB+1][LANES];
    logic [CW-1:0]       r_den  [QB+1];
    logic [SIDE_W-1:0]   r_side [QB+1];
    logic [NW-1:0]       w_dsh  [QB];
    logic [NW-1:0]       w_rem  [QB][LANES];
    logic                w_bit  [QB][LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QB-1:0], i_valid};
        end
    end

    // one quotient bit per stage, most significant first
    always_comb begin
        for (int j = 0; j < QB; j++) begin
            w_dsh[j] = NW'(r_den[j]) << (QB - 1 - j);
            for (int l = 0; l < LANES; l++) begin
                w_bit[j][l] = (r_rem[j][l] >= w_dsh[j]);
                w_rem[j][l] = w_bit[j][l] ? (r_rem[j][l] - w_dsh[j]) : r_rem[j][l];
            end
        end
    end

    // stage 0 holds the operands, each later stage the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_rem[0][l]  <= i_num[l];
                r_quot[0][l] <= '0;
            end
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int j = 0; j < QB; j++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_rem[j+1][l]  <= w_rem[j][l];
                    r_quot[j+1][l] <= {r_quot[j][l][QB-2:0], w_bit[j][l]};
                end
                r_den[j+1]  <= r_den[j];
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_side  = r_side[QB];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quot[l] = r_quot[QB][l];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lmtf_back.sv =====
// ============================================================================
// lmtf_back
// Back pipeline: rescales bright texels by 255/max, then builds the
// normal, luminance, faked color or inverted alpha form and holds the result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lmtf_back #(
    parameter int ACC_BITS = lmtf_pkg::ACC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_take,
    input  wire logic [ACC_BITS-2:0]        i_red,
    input  wire logic [ACC_BITS-2:0]        i_green,
    input  wire logic [ACC_BITS-2:0]        i_blue,
    input  wire logic [ACC_BITS-2:0]        i_max,
    input  wire lmtf_pkg::t_tag             i_tag,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [lmtf_pkg::PIX_W-1:0]      o_red,
    output logic [lmtf_pkg::PIX_W-1:0]      o_green,
    output logic [lmtf_pkg::PIX_W-1:0]      o_blue,
    output logic [lmtf_pkg::PIX_W-1:0]      o_alpha
);

    localparam int CW  = ACC_BITS - 1;
    localparam int PX  = lmtf_pkg::PIX_W;
    localparam int NW  = CW + lmtf_pkg::Q_BITS;
    localparam int SDW = lmtf_pkg::SIDE_W;

    logic w_en;

    // divider operands
    logic [CW-1:0]   w_ch_in [3];
    logic [NW-1:0]   w_num [3];
    logic [PX-1:0]   w_alpha_in;
    logic [SDW-1:0]  w_side_in;

    // divider results
    logic            w_dv_valid;
    logic [PX-1:0]   w_quot [3];
    logic [SDW-1:0]  w_side;
    lmtf_pkg::t_tag  w_tag;
    logic [PX-1:0]   w_alpha;
    logic [PX-1:0]   w_byte [3];
    logic [PX-1:0]   w_ch [3];

    // stage p1: rescaled channels and fake alpha
    logic                          r_v1;
    logic [PX-1:0]                 r_ch1 [3];
    logic [PX-1:0]                 r_alpha1;
    logic [PX-1:0]                 r_fa1;
    lmtf_pkg::t_tag                r_tag1;
    logic [lmtf_pkg::DIV3_W-1:0]   w_sum;
    logic [lmtf_pkg::DIV3_PW-1:0]  w_third;

    // stage p2: channel times fake alpha
    logic                          r_v2;
    logic [PX-1:0]                 r_ch2 [3];
    logic [2*PX-1:0]               r_prod2 [3];
    logic [PX-1:0]                 r_alpha2;
    logic [PX-1:0]                 r_fa2;
    lmtf_pkg::t_tag                r_tag2;

    // output register
    logic                          r_out_v;
    logic [PX-1:0]                 r_out [4];
    logic [lmtf_pkg::DIV255_W-1:0] w_fake [3];
    logic [PX-1:0]                 w_res [4];

    // the whole back moves unless the held result is not taken
    assign w_en   = !r_out_v || i_ready;
    assign o_take = w_en && i_valid;

    // dividend is channel * 255; alpha is 255 whenever the texel is rescaled
    always_comb begin
        w_ch_in[0] = i_red;
        w_ch_in[1] = i_green;
        w_ch_in[2] = i_blue;
        for (int l = 0; l < 3; l++) begin
            w_num[l] = (NW'(w_ch_in[l]) << lmtf_pkg::Q_BITS) - NW'(w_ch_in[l]);
        end
        w_alpha_in = i_tag.scale ? lmtf_pkg::PIX_MAX : i_max[PX-1:0];
        w_side_in  = {i_tag, w_alpha_in, w_ch_in[2][PX-1:0],
                      w_ch_in[1][PX-1:0], w_ch_in[0][PX-1:0]};
    end

    lmtf_div #(
        .CW     (CW),
        .LANES  (3),
        .SIDE_W (SDW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_num   (w_num),
        .i_den   (i_max),
        .i_side  (w_side_in),
        .o_valid (w_dv_valid),
        .o_quot  (w_quot),
        .o_side  (w_side)
    );

    // pick scaled or plain bytes, then fake alpha = 255 - ceil(sum/3)
    always_comb begin
        w_tag     = lmtf_pkg::t_tag'(w_side[SDW-1 -: lmtf_pkg::TAG_W]);
        w_alpha   = w_side[3*PX +: PX];
        w_byte[0] = w_side[0 +: PX];
        w_byte[1] = w_side[PX +: PX];
        w_byte[2] = w_side[2*PX +: PX];
        for (int l = 0; l < 3; l++) begin
            w_ch[l] = w_tag.scale ? w_quot[l] : w_byte[l];
        end
        w_sum   = lmtf_pkg::DIV3_W'(w_ch[0]) + lmtf_pkg::DIV3_W'(w_ch[1])
                + lmtf_pkg::DIV3_W'(w_ch[2]);
        w_third = lmtf_pkg::DIV3_PW'(w_sum + lmtf_pkg::DIV3_BIAS)
                * lmtf_pkg::DIV3_PW'(lmtf_pkg::DIV3_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_v1    <= w_dv_valid;
            r_v2    <= r_v1;
            r_out_v <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ch1    <= w_ch;
            r_alpha1 <= w_alpha;
            r_fa1    <= lmtf_pkg::PIX_MAX - w_third[lmtf_pkg::DIV3_SHIFT +: PX];
            r_tag1   <= w_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_prod2[l] <= (2*PX)'(r_ch1[l]) * (2*PX)'(r_fa1);
            end
            r_ch2    <= r_ch1;
            r_alpha2 <= r_alpha1;
            r_fa2    <= r_fa1;
            r_tag2   <= r_tag1;
        end
    end

    // product / 255, then the mode picks the final texel
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_fake[l] = lmtf_pkg::DIV255_W'(r_prod2[l]) + lmtf_pkg::DIV255_W'(1)
                      + lmtf_pkg::DIV255_W'(r_prod2[l][2*PX-1:PX]);
        end
        case (r_tag2.mode)
            lmtf_pkg::MODE_NORMAL: begin
                w_res[0] = r_ch2[0];
                w_res[1] = r_ch2[1];
                w_res[2] = r_ch2[2];
                w_res[3] = r_alpha2;
            end
            lmtf_pkg::MODE_LUMA: begin
                w_res[0] = r_alpha2;
                w_res[1] = '0;
                w_res[2] = '0;
                w_res[3] = r_alpha2;
            end
            lmtf_pkg::MODE_FAKE: begin
                w_res[0] = w_fake[0][PX +: PX];
                w_res[1] = w_fake[1][PX +: PX];
                w_res[2] = w_fake[2][PX +: PX];
                w_res[3] = r_fa2;
            end
            default: begin
                w_res[0] = '0;
                w_res[1] = '0;
                w_res[2] = '0;
                w_res[3] = lmtf_pkg::PIX_MAX - r_alpha2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_v;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];
    assign o_alpha = r_out[3];

endmodule

`default_nettype wire

// ===== hdl/lightmap_texel_finalize.sv =====
// ============================================================================
// lightmap_texel_finalize
// Throughput: one texel per cycle while results are taken; the rescale
// divider and the mode stages are fully pipelined, a four-entry queue
// joins front and back.
// Reset: synchronous active low; empties all stages and the queue, sets
// saturation to full color and the mode to normal.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lightmap_texel_finalize #(
    parameter int ACC_BITS = lmtf_pkg::ACC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input texel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [ACC_BITS-1:0]    i_in_red,
    input  wire logic signed [ACC_BITS-1:0]    i_in_green,
    input  wire logic signed [ACC_BITS-1:0]    i_in_blue,
    // finished texel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [lmtf_pkg::PIX_W-1:0]         o_out_red,
    output logic [lmtf_pkg::PIX_W-1:0]         o_out_green,
    output logic [lmtf_pkg::PIX_W-1:0]         o_out_blue,
    output logic [lmtf_pkg::PIX_W-1:0]         o_out_alpha,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lmtf_pkg::APB_AW-1:0]   paddr,
    input  wire logic [lmtf_pkg::APB_DW-1:0]   pwdata,
    output logic [lmtf_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);

    localparam int CW = ACC_BITS - 1;
    localparam int QW = 4*CW + lmtf_pkg::TAG_W;

    logic [lmtf_pkg::SAT_W-1:0] r_saturation;
    lmtf_pkg::t_mode            r_mono_mode;
    lmtf_pkg::t_reg_idx         w_idx;

    logic            f_valid;
    logic [CW-1:0]   f_red;
    logic [CW-1:0]   f_green;
    logic [CW-1:0]   f_blue;
    logic [CW-1:0]   f_max;
    lmtf_pkg::t_tag  f_tag;

    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic [QW-1:0]   q_wdata;
    logic [QW-1:0]   q_rdata;
    lmtf_pkg::t_tag  q_tag;

    // register file: word address selects the register
    assign w_idx  = lmtf_pkg::t_reg_idx'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saturation <= lmtf_pkg::SAT_FULL;
            r_mono_mode  <= lmtf_pkg::MODE_NORMAL;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                lmtf_pkg::REG_SATURATION: r_saturation <= pwdata[lmtf_pkg::SAT_W-1:0];
                lmtf_pkg::REG_MONO_MODE:  r_mono_mode  <= lmtf_pkg::t_mode'(pwdata[1:0]);
                default:                  r_saturation <= r_saturation;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lmtf_pkg::REG_SATURATION: prdata = lmtf_pkg::APB_DW'(r_saturation);
            lmtf_pkg::REG_MONO_MODE:  prdata = lmtf_pkg::APB_DW'(r_mono_mode);
            default:                  prdata = '0;
        endcase
    end

    lmtf_front #(
        .ACC_BITS (ACC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_red        (i_in_red),
        .i_green      (i_in_green),
        .i_blue       (i_in_blue),
        .i_saturation (r_saturation),
        .i_mode       (r_mono_mode),
        .o_valid      (f_valid),
        .i_ready      (!q_full),
        .o_red        (f_red),
        .o_green      (f_green),
        .o_blue       (f_blue),
        .o_max        (f_max),
        .o_tag        (f_tag)
    );

    assign q_wdata = {f_tag, f_max, f_blue, f_green, f_red};
    assign q_tag   = lmtf_pkg::t_tag'(q_rdata[QW-1 -: lmtf_pkg::TAG_W]);

    lmtf_queue #(
        .WIDTH (QW),
        .DEPTH (lmtf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    lmtf_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_empty),
        .o_take  (q_pop),
        .i_red   (q_rdata[0 +: CW]),
        .i_green (q_rdata[CW +: CW]),
        .i_blue  (q_rdata[2*CW +: CW]),
        .i_max   (q_rdata[3*CW +: CW]),
        .i_tag   (q_tag),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_red   (o_out_red),
        .o_green (o_out_green),
        .o_blue  (o_out_blue),
        .o_alpha (o_out_alpha)
    );

endmodule

`default_nettype wire

// ===== hdl/lmtf_chk.sv =====
// ============================================================================
// lmtf_chk
// Port-level checks for the lightmap texel finalize block, bound to the top.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lmtf_chk #(
    parameter int ACC_BITS = lmtf_pkg::ACC_BITS_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic signed [ACC_BITS-1:0]    i_in_red,
    input wire logic signed [ACC_BITS-1:0]    i_in_green,
    input wire logic signed [ACC_BITS-1:0]    i_in_blue,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [lmtf_pkg::PIX_W-1:0]    o_out_red,
    input wire logic [lmtf_pkg::PIX_W-1:0]    o_out_green,
    input wire logic [lmtf_pkg::PIX_W-1:0]    o_out_blue,
    input wire logic [lmtf_pkg::PIX_W-1:0]    o_out_alpha,
    input wire logic                          psel,
    input wire logic                          penable,
    input wire logic                          pwrite,
    input wire logic [lmtf_pkg::APB_AW-1:0]   paddr,
    input wire logic [lmtf_pkg::APB_DW-1:0]   pwdata,
    input wire logic [lmtf_pkg::APB_DW-1:0]   prdata,
    input wire logic                          pready
);

    // a held result stays offered until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    // a held result keeps its bytes
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_red) && $stable(o_out_green)
            && $stable(o_out_blue) && $stable(o_out_alpha))
        else $error("held result changed");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // an empty block takes input right after reset
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

    // mode register reads back what was just written
    a_mode_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && psel && penable && pwrite && pready && paddr[2])
            ##1 (psel && !pwrite && paddr[2])
        |-> prdata[1:0] == $past(pwdata[1:0]))
        else $error("mode register readback mismatch");

endmodule

bind lightmap_texel_finalize lmtf_chk #(.ACC_BITS(ACC_BITS)) u_lmtf_chk (.*);

`default_nettype wire
